FILE: rtl/core/acec_pkg.sv
// Shared types, constants and helper functions for the alignment CIGAR edit classifier.
// It depends on nothing. Every other file in rtl/core imports it.
package acec_pkg;

   // Cap on run lengths, totals and the collapsed position.
   localparam int MAX_COLUMNS = 256;
   localparam int CNT_W = 9;
   localparam logic [CNT_W-1:0] COUNT_CAP =
      (MAX_COLUMNS < 511) ? CNT_W'(MAX_COLUMNS) : CNT_W'(511);

   // Column characters.
   localparam logic [7:0] GAP_CHAR = 8'd45;

   // Operation codes.
   localparam logic [1:0] OP_MATCH = 2'd0;
   localparam logic [1:0] OP_DEL   = 2'd1;
   localparam logic [1:0] OP_INS   = 2'd2;
   localparam logic [1:0] OP_MIS   = 2'd3;

   // Control register indexes and reset values.
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_CUT_POSITION = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_HALF  = 1'b1;
   localparam logic [7:0] CUT_POSITION_RESET = 8'd34;
   localparam logic [7:0] WINDOW_HALF_RESET  = 8'd4;

   // Result queue geometry.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // One result word.
   typedef struct packed {
      logic [CNT_W-1:0] run_length;
      logic [1:0]       run_op;
      logic             last_run;
      logic             edited;
      logic [CNT_W-1:0] insertion_columns;
      logic [CNT_W-1:0] nonmatch_runs;
   } acec_result_type;

   // Words produced by one column: the run closed by an operation change,
   // then the final run of the alignment.
   typedef struct packed {
      logic            change_valid;
      acec_result_type change_word;
      logic            last_valid;
      acec_result_type last_word;
   } acec_push_type;

   // Column class from the two characters.
   function automatic logic [1:0] classify(input logic [7:0] r, input logic [7:0] t);
      logic [1:0] op;
      if (r == t) begin
         op = OP_MATCH;
      end else if (r != GAP_CHAR && t == GAP_CHAR) begin
         op = OP_DEL;
      end else if (r == GAP_CHAR && t != GAP_CHAR) begin
         op = OP_INS;
      end else begin
         op = OP_MIS;
      end
      return op;
   endfunction

   // Saturating increment.
   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v < COUNT_CAP) ? CNT_W'(v + 1'b1) : v;
   endfunction

   // True when pos lies in [cut - half + 1, cut + half], written without signs.
   function automatic logic in_window(input logic [CNT_W-1:0] pos,
                                      input logic [7:0] cut,
                                      input logic [7:0] half);
      logic [CNT_W:0] pos_plus;
      logic [CNT_W:0] hi;
      pos_plus = {1'b0, pos} + {2'b00, half};
      hi       = {2'b00, cut} + {2'b00, half};
      return (pos_plus > {2'b00, cut}) && ({1'b0, pos} <= hi);
   endfunction

endpackage

FILE: rtl/core/acec_if.sv
// Handshake interfaces for the column channel and the result channel.
// The result interface depends on acec_pkg for the counter width.
interface acec_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ref_char;
   logic [7:0] target_char;
   logic       last_column;

   modport source(output valid, output ref_char, output target_char,
                  output last_column, input ready);
   modport sink(input valid, input ref_char, input target_char,
                input last_column, output ready);
endinterface

interface acec_rsp_if;
   import acec_pkg::*;
   logic             valid;
   logic             ready;
   logic [CNT_W-1:0] run_length;
   logic [1:0]       run_op;
   logic             last_run;
   logic             edited;
   logic [CNT_W-1:0] insertion_columns;
   logic [CNT_W-1:0] nonmatch_runs;

   modport source(output valid, output run_length, output run_op, output last_run,
                  output edited, output insertion_columns, output nonmatch_runs,
                  input ready);
   modport sink(input valid, input run_length, input run_op, input last_run,
                input edited, input insertion_columns, input nonmatch_runs,
                output ready);
endinterface

FILE: rtl/core/acec_column_stage.sv
// Column register and run-length/edit-window logic of the classifier.
// It depends on acec_pkg and acec_req_if. It feeds words into acec_result_queue.
module acec_column_stage
   import acec_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   acec_req_if.sink      req_chan,
   input  logic [7:0]    cut_position,
   input  logic [7:0]    window_half,
   input  logic          queue_room,
   output acec_push_type push
);

   // Column register.
   logic       stg_valid_ff, stg_valid_in;
   logic [7:0] stg_ref_ff, stg_target_ff;
   logic       stg_last_ff;
   logic       accept;
   logic       advance;

   // Alignment state.
   logic [1:0]       cur_op_ff, cur_op_in;
   logic [CNT_W-1:0] cur_count_ff, cur_count_in;
   logic [CNT_W-1:0] cpos_ff, cpos_in;
   logic             lead_ins_ff, lead_ins_in;
   logic             edit_ff, edit_in;
   logic [CNT_W-1:0] ins_total_ff, ins_total_in;
   logic [CNT_W-1:0] nm_total_ff, nm_total_in;

   // Column work.
   logic [1:0]       op;
   logic             change;
   logic [1:0]       op_new;
   logic [CNT_W-1:0] count_new;
   logic [CNT_W-1:0] nm_mid;
   logic [CNT_W-1:0] nm_fin;
   logic [CNT_W-1:0] ins_new;
   logic [CNT_W-1:0] cpos_new;
   logic             lead_new;
   logic             check_col;
   logic [CNT_W-1:0] check_pos;
   logic             hit_col;
   logic             hit_lead;
   logic             edit_new;

   // A word moves into the column register when it is empty or draining.
   assign advance        = stg_valid_ff && queue_room;
   assign req_chan.ready = !stg_valid_ff || queue_room;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      if (accept) begin
         stg_valid_in = 1'b1;
      end else if (advance) begin
         stg_valid_in = 1'b0;
      end else begin
         stg_valid_in = stg_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stg_ref_ff    <= req_chan.ref_char;
         stg_target_ff <= req_chan.target_char;
         stg_last_ff   <= req_chan.last_column;
      end
   end

   // Run tracking: extend the open run or close it on an operation change.
   always_comb begin
      op     = classify(stg_ref_ff, stg_target_ff);
      change = 1'b0;
      if (cur_count_ff == '0) begin
         op_new    = op;
         count_new = CNT_W'(1);
      end else if (op == cur_op_ff) begin
         op_new    = cur_op_ff;
         count_new = sat_inc(cur_count_ff);
      end else begin
         change    = 1'b1;
         op_new    = op;
         count_new = CNT_W'(1);
      end
      nm_mid = (change && cur_op_ff != OP_MATCH) ? sat_inc(nm_total_ff) : nm_total_ff;
      nm_fin = (op_new != OP_MATCH) ? sat_inc(nm_mid) : nm_mid;
   end

   // Collapsed position and the cut-site window check.
   always_comb begin
      ins_new   = ins_total_ff;
      cpos_new  = cpos_ff;
      lead_new  = lead_ins_ff;
      check_col = 1'b0;
      check_pos = cpos_ff;
      if (op == OP_INS) begin
         ins_new = sat_inc(ins_total_ff);
         if (cpos_ff != '0) begin
            check_col = 1'b1;
            check_pos = CNT_W'(cpos_ff - 1'b1);
         end else begin
            lead_new = 1'b1;
         end
      end else begin
         check_col = (op != OP_MATCH) || (cpos_ff == '0 && lead_ins_ff);
         cpos_new  = sat_inc(cpos_ff);
      end
      hit_col  = check_col && in_window(check_pos, cut_position, window_half);
      // An alignment of insertions only still marks position zero.
      hit_lead = stg_last_ff && cpos_new == '0 && lead_new &&
                 in_window('0, cut_position, window_half);
      edit_new = edit_ff || hit_col || hit_lead;
   end

   // Words handed to the queue.
   always_comb begin
      push.change_valid                  = advance && change;
      push.change_word.run_length        = cur_count_ff;
      push.change_word.run_op            = cur_op_ff;
      push.change_word.last_run          = 1'b0;
      push.change_word.edited            = 1'b0;
      push.change_word.insertion_columns = '0;
      push.change_word.nonmatch_runs     = '0;
      push.last_valid                    = advance && stg_last_ff;
      push.last_word.run_length          = count_new;
      push.last_word.run_op              = op_new;
      push.last_word.last_run            = 1'b1;
      push.last_word.edited              = edit_new;
      push.last_word.insertion_columns   = ins_new;
      push.last_word.nonmatch_runs       = nm_fin;
   end

   // State update; the last column returns everything to reset.
   always_comb begin
      cur_op_in    = cur_op_ff;
      cur_count_in = cur_count_ff;
      cpos_in      = cpos_ff;
      lead_ins_in  = lead_ins_ff;
      edit_in      = edit_ff;
      ins_total_in = ins_total_ff;
      nm_total_in  = nm_total_ff;
      if (advance) begin
         if (stg_last_ff) begin
            cur_op_in    = OP_MATCH;
            cur_count_in = '0;
            cpos_in      = '0;
            lead_ins_in  = 1'b0;
            edit_in      = 1'b0;
            ins_total_in = '0;
            nm_total_in  = '0;
         end else begin
            cur_op_in    = op_new;
            cur_count_in = count_new;
            cpos_in      = cpos_new;
            lead_ins_in  = lead_new;
            edit_in      = edit_new;
            ins_total_in = ins_new;
            nm_total_in  = nm_mid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_op_ff    <= OP_MATCH;
         cur_count_ff <= '0;
         cpos_ff      <= '0;
         lead_ins_ff  <= 1'b0;
         edit_ff      <= 1'b0;
         ins_total_ff <= '0;
         nm_total_ff  <= '0;
      end else begin
         cur_op_ff    <= cur_op_in;
         cur_count_ff <= cur_count_in;
         cpos_ff      <= cpos_in;
         lead_ins_ff  <= lead_ins_in;
         edit_ff      <= edit_in;
         ins_total_ff <= ins_total_in;
         nm_total_ff  <= nm_total_in;
      end
   end

endmodule

FILE: rtl/core/acec_result_queue.sv
// Small result queue that takes up to two words a cycle and sends one a cycle while the result side is ready.
// It depends on acec_pkg and acec_rsp_if.
module acec_result_queue
   import acec_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  acec_push_type push,
   output logic          queue_room,
   acec_rsp_if.source    rsp_chan
);

   acec_result_type   queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic [1:0]        n_push;
   logic              pop;
   acec_result_type   word_a;
   acec_result_type   word_b;
   acec_result_type   head;

   // Room for two words, so a column never has to stall halfway.
   assign queue_room = count_ff <= QCNT_W'(QUEUE_DEPTH - 2);

   // Order the words: the closed run goes ahead of the final run.
   always_comb begin
      n_push = 2'(push.change_valid) + 2'(push.last_valid);
      word_a = push.change_valid ? push.change_word : push.last_word;
      word_b = push.last_word;
   end

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         queue_ff[wr_ptr_ff] <= word_a;
      end
      if (n_push == 2'd2) begin
         queue_ff[QPTR_W'(wr_ptr_ff + 1'b1)] <= word_b;
      end
   end

   // Pointer and fill count.
   assign pop       = rsp_chan.valid && rsp_chan.ready;
   assign wr_ptr_in = QPTR_W'(wr_ptr_ff + n_push);
   assign rd_ptr_in = pop ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
   assign count_in  = QCNT_W'(count_ff + QCNT_W'(n_push) - QCNT_W'(pop));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Head of the queue drives the result channel.
   assign head                       = queue_ff[rd_ptr_ff];
   assign rsp_chan.valid             = count_ff != '0;
   assign rsp_chan.run_length        = head.run_length;
   assign rsp_chan.run_op            = head.run_op;
   assign rsp_chan.last_run          = head.last_run;
   assign rsp_chan.edited            = head.edited;
   assign rsp_chan.insertion_columns = head.insertion_columns;
   assign rsp_chan.nonmatch_runs     = head.nonmatch_runs;

endmodule

FILE: rtl/core/alignment_cigar_edit_classifier_top.sv
// Top level of the alignment CIGAR edit classifier: control registers, column stage, queue.
// It depends on acec_pkg, acec_if, acec_column_stage and acec_result_queue.
//
// The block takes one aligned column per clock, unless the column channel stalls, and
// turns the stream into CIGAR runs (0 match, 1 deletion, 2 insertion, 3 mismatch). A
// column goes into a column register, is classified against the open run there, and its
// words are then written into a four-word result queue whose head drives the result
// channel. A column that both closes a run and ends the alignment yields two words; the
// queue sends one word per cycle while the result side is ready, so the sustained column
// rate is one per cycle as long as the result side keeps up, and the column channel
// stalls only while the queue has fewer than two free slots. The final run carries the
// edit flag, the insertion column count and the number of non-match runs; other runs
// carry zeros there. cut_position and window_half should be written only while no
// alignment is in flight.
module alignment_cigar_edit_classifier_top
   import acec_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   acec_req_if.sink             req_chan,
   acec_rsp_if.source           rsp_chan,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_write_data
);

   logic [7:0]    cut_position_ff, cut_position_in;
   logic [7:0]    window_half_ff, window_half_in;
   logic          queue_room;
   acec_push_type push;

   // Control register writes.
   always_comb begin
      cut_position_in = cut_position_ff;
      window_half_in  = window_half_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_CUT_POSITION: begin
               cut_position_in = csr_write_data;
            end
            CSR_WINDOW_HALF: begin
               window_half_in = csr_write_data;
            end
            default: begin
               cut_position_in = cut_position_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cut_position_ff <= CUT_POSITION_RESET;
         window_half_ff  <= WINDOW_HALF_RESET;
      end else begin
         cut_position_ff <= cut_position_in;
         window_half_ff  <= window_half_in;
      end
   end

   // Column stage.
   acec_column_stage u_column_stage (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .cut_position (cut_position_ff),
      .window_half  (window_half_ff),
      .queue_room   (queue_room),
      .push         (push)
   );

   // Result queue.
   acec_result_queue u_result_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .queue_room (queue_room),
      .rsp_chan   (rsp_chan)
   );

   // Words enter the queue only when it has room for two.
   a_push_needs_room: assert property (@(posedge clock) disable iff (reset)
      (push.change_valid || push.last_valid) |-> queue_room)
      else $error("word pushed into a full result queue");

   // A column that closes a run and ends the alignment opens a different operation.
   a_two_words_differ: assert property (@(posedge clock) disable iff (reset)
      (push.change_valid && push.last_valid) |->
      (push.change_word.run_op != push.last_word.run_op))
      else $error("closed run and final run share an operation");

   // Every run sent covers at least one column.
   a_run_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.run_length != '0))
      else $error("empty run sent");

   // Summary fields are zero except on the final run.
   a_summary_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.last_run) |->
      (!rsp_chan.edited && rsp_chan.insertion_columns == '0 &&
       rsp_chan.nonmatch_runs == '0))
      else $error("summary fields set on an inner run");

endmodule

FILE: sim/alignment_cigar_edit_classifier_top_tb.sv
// Self-checking testbench for the alignment CIGAR edit classifier: directed columns, then
// random alignments, checked word by word against a run-length and edit-window predictor.
// It depends on acec_pkg, acec_if and alignment_cigar_edit_classifier_top.
module alignment_cigar_edit_classifier_top_tb;
   import acec_pkg::*;

   localparam int QUIET_LIMIT     = 1000;
   localparam int RSP_HOLD_CYCLES = 90;
   localparam int SETTLE_CYCLES   = 8;
   localparam int PHASE_COLUMNS   = 80;
   localparam int PHASE_COUNT     = 10;
   localparam logic [8:0] RUN_CAP = 9'd256;

   // One row of the directed part; typed rows carry their own expected word.
   typedef struct {
      logic [7:0]      r;
      logic [7:0]      t;
      bit              last;
      bit              typed;
      acec_result_type want;
   } column_row_type;

   logic clock = 1'b0;
   logic reset;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [7:0]           csr_write_data;

   acec_req_if req_chan();
   acec_rsp_if rsp_chan();

   alignment_cigar_edit_classifier_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Predictor state and its copy of the registers.
   logic [7:0] cut_setting  = CUT_POSITION_RESET;
   logic [7:0] half_setting = WINDOW_HALF_RESET;
   logic [1:0] open_op        = OP_MATCH;
   logic [8:0] open_len       = '0;
   logic [8:0] next_pos       = '0;
   bit         lead_ins_seen  = 1'b0;
   bit         edit_hit       = 1'b0;
   logic [8:0] ins_columns    = '0;
   logic [8:0] nonmatch_count = '0;

   acec_result_type expected_runs[$];
   column_row_type  directed_rows[$];

   int error_count     = 0;
   int words_checked   = 0;
   int columns_sent    = 0;
   int alignments_sent = 0;
   int settings_used   = 1;
   int quiet_cycles    = 0;
   int req_idle_pct    = 0;
   int rsp_idle_pct    = 0;
   int rsp_hold_requests = 0;
   int rsp_holds_done    = 0;

   always #6 clock = ~clock;

   function automatic logic [8:0] sat_step(input logic [8:0] v);
      return (v < RUN_CAP) ? v + 9'd1 : v;
   endfunction

   function automatic logic [1:0] column_class(input logic [7:0] r, input logic [7:0] t);
      if (r == t) return OP_MATCH;
      if (r != GAP_CHAR && t == GAP_CHAR) return OP_DEL;
      if (r == GAP_CHAR && t != GAP_CHAR) return OP_INS;
      return OP_MIS;
   endfunction

   function automatic acec_result_type make_word(input logic [8:0] len, input logic [1:0] op,
                                                 input bit last, input bit ed,
                                                 input logic [8:0] ins, input logic [8:0] nm);
      acec_result_type w;
      w.run_length        = len;
      w.run_op            = op;
      w.last_run          = last;
      w.edited            = ed;
      w.insertion_columns = ins;
      w.nonmatch_runs     = nm;
      return w;
   endfunction

   // Appends one word to the expected sequence.
   task automatic add_expected(input acec_result_type w);
      expected_runs.insert(expected_runs.size(), w);
   endtask

   function automatic logic [7:0] pick_base();
      case ($urandom_range(4))
         0: return "A";
         1: return "C";
         2: return "G";
         3: return "T";
         default: return "N";
      endcase
   endfunction

   // Flags an edit when a non-match collapsed position falls inside the cut-site window.
   task automatic note_nonmatch(input logic [8:0] pos);
      int lo;
      int hi;
      lo = int'(cut_setting) - int'(half_setting) + 1;
      hi = int'(cut_setting) + int'(half_setting);
      if (int'(pos) >= lo && int'(pos) <= hi) edit_hit = 1'b1;
   endtask

   // Advances the run encoder by one column and queues the words it produces.
   task automatic predict_column_runs(input logic [7:0] r, input logic [7:0] t,
                                      input bit last, input bit keep);
      logic [1:0] op;
      op = column_class(r, t);
      if (open_len == 0) begin
         open_op  = op;
         open_len = 9'd1;
      end else if (op == open_op) begin
         open_len = sat_step(open_len);
      end else begin
         if (keep) add_expected(make_word(open_len, open_op, 1'b0, 1'b0, 9'd0, 9'd0));
         if (open_op != OP_MATCH) nonmatch_count = sat_step(nonmatch_count);
         open_op  = op;
         open_len = 9'd1;
      end

      // Insertion columns mark the position before them; others take a position.
      if (op == OP_INS) begin
         ins_columns = sat_step(ins_columns);
         if (next_pos > 0) note_nonmatch(next_pos - 9'd1);
         else lead_ins_seen = 1'b1;
      end else begin
         if (op != OP_MATCH || (next_pos == 0 && lead_ins_seen)) note_nonmatch(next_pos);
         next_pos = sat_step(next_pos);
      end

      // The last column closes the open run and reports the alignment summary.
      if (last) begin
         if (open_op != OP_MATCH) nonmatch_count = sat_step(nonmatch_count);
         if (next_pos == 0 && lead_ins_seen) note_nonmatch(9'd0);
         if (keep) begin
            add_expected(make_word(open_len, open_op, 1'b1, edit_hit,
                                   ins_columns, nonmatch_count));
         end
         open_op        = OP_MATCH;
         open_len       = '0;
         next_pos       = '0;
         lead_ins_seen  = 1'b0;
         edit_hit       = 1'b0;
         ins_columns    = '0;
         nonmatch_count = '0;
      end
   endtask

   // Offers one column word, after an optional idle burst, and predicts it once taken.
   task automatic send_column(input logic [7:0] r, input logic [7:0] t, input bit last,
                              input bit keep = 1'b1);
      int gap;
      @(negedge clock);
      if (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct) begin
         gap = $urandom_range(1, 15);
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.ref_char    <= r;
      req_chan.target_char <= t;
      req_chan.last_column <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predict_column_runs(r, t, last, keep);
      columns_sent++;
   endtask

   task automatic source_idle();
      @(negedge clock);
      req_chan.valid <= 1'b0;
   endtask

   task automatic wait_for_results();
      while (expected_runs.size() != 0) @(posedge clock);
   endtask

   // Character pair for a column of the given class.
   task automatic make_column(input logic [1:0] cls, output logic [7:0] r,
                              output logic [7:0] t);
      logic [7:0] base;
      base = pick_base();
      case (cls)
         OP_MATCH: begin
            r = ($urandom_range(19) == 0) ? GAP_CHAR : base;
            t = r;
         end
         OP_DEL: begin
            r = base;
            t = GAP_CHAR;
         end
         OP_INS: begin
            r = GAP_CHAR;
            t = base;
         end
         default: begin
            r = base;
            t = pick_base();
            if (t == r) t = (r == "A") ? "C" : "A";
         end
      endcase
   endtask

   task automatic send_class_run(input logic [1:0] cls, input int count, input bit end_it);
      logic [7:0] r;
      logic [7:0] t;
      for (int k = 0; k < count; k++) begin
         make_column(cls, r, t);
         send_column(r, t, end_it && k == count - 1);
      end
   endtask

   // A random alignment: runs of well-formed columns with some raw byte noise.
   task automatic send_alignment(input int columns, input int noise_pct);
      logic [1:0] cls;
      logic [7:0] r;
      logic [7:0] t;
      cls = 2'($urandom_range(3));
      for (int k = 0; k < columns; k++) begin
         if ($urandom_range(99) < 35) cls = 2'($urandom_range(3));
         if ($urandom_range(99) < noise_pct) begin
            r = 8'($urandom_range(255));
            t = ($urandom_range(3) == 0) ? r : 8'($urandom_range(255));
         end else begin
            make_column(cls, r, t);
         end
         send_column(r, t, k == columns - 1);
      end
      alignments_sent++;
   endtask

   // Settings change only with the block idle and every word delivered.
   task automatic write_settings(input logic [7:0] cut, input logic [7:0] half);
      source_idle();
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_CUT_POSITION;
      csr_write_data   <= cut;
      @(negedge clock);
      csr_index        <= CSR_WINDOW_HALF;
      csr_write_data   <= half;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      cut_setting  = cut;
      half_setting = half;
      settings_used++;
   endtask

   task automatic add_row(input logic [7:0] r, input logic [7:0] t, input bit last,
                          input bit typed = 1'b0, input logic [1:0] op = OP_MATCH,
                          input bit ins = 1'b0, input bit nm = 1'b0);
      column_row_type row;
      row.r     = r;
      row.t     = t;
      row.last  = last;
      row.typed = typed;
      row.want  = make_word(9'd1, op, 1'b1, 1'b0, 9'(ins), 9'(nm));
      directed_rows.insert(directed_rows.size(), row);
   endtask

   // Result checker: every delivered word against the oldest expectation.
   always @(posedge clock) begin : check_results
      acec_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_runs.size() == 0) begin
            $error("unexpected result word: run_length %0d run_op %0d last_run %0d",
                   rsp_chan.run_length, rsp_chan.run_op, rsp_chan.last_run);
            error_count++;
         end else begin
            want = expected_runs.pop_front();
            words_checked++;
            if (rsp_chan.run_length !== want.run_length) begin
               $error("run_length: expected %0d, got %0d", want.run_length,
                      rsp_chan.run_length);
               error_count++;
            end
            if (rsp_chan.run_op !== want.run_op) begin
               $error("run_op: expected %0d, got %0d", want.run_op, rsp_chan.run_op);
               error_count++;
            end
            if (rsp_chan.last_run !== want.last_run) begin
               $error("last_run: expected %0d, got %0d", want.last_run, rsp_chan.last_run);
               error_count++;
            end
            if (rsp_chan.edited !== want.edited) begin
               $error("edited: expected %0d, got %0d", want.edited, rsp_chan.edited);
               error_count++;
            end
            if (rsp_chan.insertion_columns !== want.insertion_columns) begin
               $error("insertion_columns: expected %0d, got %0d", want.insertion_columns,
                      rsp_chan.insertion_columns);
               error_count++;
            end
            if (rsp_chan.nonmatch_runs !== want.nonmatch_runs) begin
               $error("nonmatch_runs: expected %0d, got %0d", want.nonmatch_runs,
                      rsp_chan.nonmatch_runs);
               error_count++;
            end
         end
      end
   end

   // Watchdog: too long without a word moving on either channel ends the run.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Result side: random stall bursts, plus one long hold-off on request.
   initial begin : result_sink
      int gap;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_holds_done != rsp_hold_requests) begin
            rsp_chan.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(negedge clock);
            rsp_holds_done++;
            rsp_chan.ready <= 1'b1;
         end else if (rsp_idle_pct != 0 && $urandom_range(99) < rsp_idle_pct) begin
            gap = $urandom_range(1, 15);
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(negedge clock);
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      logic [7:0] cut;
      logic [7:0] half;
      int phase_start;
      int len;

      reset                = 1'b1;
      csr_write_enable     = 1'b0;
      csr_index            = CSR_CUT_POSITION;
      csr_write_data       = '0;
      req_chan.valid       = 1'b0;
      req_chan.ref_char    = '0;
      req_chan.target_char = '0;
      req_chan.last_column = 1'b0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Single-column alignments under the reset window (31 to 38): never edited.
      add_row("A", "A", 1'b1, 1'b1, OP_MATCH, 1'b0, 1'b0);
      add_row("G", GAP_CHAR, 1'b1, 1'b1, OP_DEL, 1'b0, 1'b1);
      add_row(GAP_CHAR, "C", 1'b1, 1'b1, OP_INS, 1'b1, 1'b1);
      add_row("A", "T", 1'b1, 1'b1, OP_MIS, 1'b0, 1'b1);
      add_row(GAP_CHAR, GAP_CHAR, 1'b1, 1'b1, OP_MATCH, 1'b0, 1'b0);
      add_row(8'hFF, 8'h00, 1'b1, 1'b1, OP_MIS, 1'b0, 1'b1);
      add_row(8'h00, 8'h00, 1'b1, 1'b1, OP_MATCH, 1'b0, 1'b0);
      add_row(8'hD2, GAP_CHAR, 1'b1, 1'b1, OP_DEL, 1'b0, 1'b1);
      // Every operation in one alignment.
      add_row("A", "A", 1'b0);
      add_row("C", "C", 1'b0);
      add_row("G", GAP_CHAR, 1'b0);
      add_row("T", GAP_CHAR, 1'b0);
      add_row(GAP_CHAR, "A", 1'b0);
      add_row(GAP_CHAR, "G", 1'b0);
      add_row("A", "T", 1'b0);
      add_row("A", "A", 1'b1);
      // Leading insertions mark position zero.
      add_row(GAP_CHAR, "A", 1'b0);
      add_row(GAP_CHAR, 8'hD2, 1'b0);
      add_row("G", "G", 1'b0);
      add_row("G", "T", 1'b1);
      // Operation change on the last column gives two words at once.
      add_row("A", "A", 1'b0);
      add_row("A", "C", 1'b1);
      add_row(8'hFF, 8'hFF, 1'b0);
      add_row(8'hFF, 8'h7F, 1'b1);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].typed) add_expected(directed_rows[i].want);
         send_column(directed_rows[i].r, directed_rows[i].t, directed_rows[i].last,
                     !directed_rows[i].typed);
         if (directed_rows[i].last) alignments_sent++;
      end

      // Random phases, each under its own window setting.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0: begin cut = 8'd0;   half = 8'd0;   end
            1: begin cut = 8'd255; half = 8'd128; end
            2: begin cut = 8'd0;   half = 8'd128; end
            3: begin cut = 8'd255; half = 8'd0;   end
            4: begin cut = 8'd1;   half = 8'd1;   end
            PHASE_COUNT - 1: begin cut = CUT_POSITION_RESET; half = WINDOW_HALF_RESET; end
            default: begin
               cut  = 8'($urandom_range(60));
               half = ($urandom_range(3) == 0) ? 8'($urandom_range(128))
                                               : 8'($urandom_range(1, 20));
            end
         endcase
         write_settings(cut, half);

         // Some phases run with no idling at all, the last one among them.
         if (p == PHASE_COUNT - 1 || p % 3 == 2) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end else begin
            req_idle_pct = 8;
            rsp_idle_pct = 8;
         end

         // Saturating runs, positions and insertion totals.
         if (p == 1) begin
            send_class_run(OP_MATCH, 270, 1'b0);
            send_class_run(OP_INS, 270, 1'b1);
            alignments_sent++;
         end
         // Alternating runs push the non-match run total past its cap.
         if (p == 2) begin
            for (int k = 0; k < 520; k++) begin
               send_class_run((k % 2) ? OP_DEL : OP_MATCH, 1, k == 519);
            end
            alignments_sent++;
         end
         // Long result-side hold-off while columns keep coming.
         if (p == 3) begin
            rsp_hold_requests++;
            send_alignment(60, 0);
         end
         // Pause the columns mid-alignment until every pending word is out.
         if (p == 4) begin
            send_class_run(OP_DEL, 3, 1'b0);
            send_class_run(OP_MATCH, 2, 1'b0);
            send_class_run(OP_MIS, 2, 1'b0);
            source_idle();
            wait_for_results();
            send_class_run(OP_INS, 2, 1'b1);
            alignments_sent++;
         end

         phase_start = columns_sent;
         while (columns_sent - phase_start < PHASE_COLUMNS) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
            send_alignment(len, 8);
         end
      end

      source_idle();
      wait_for_results();
      repeat (12) @(posedge clock);

      $display("Sent %0d columns in %0d alignments under %0d window settings;",
               columns_sent, alignments_sent, settings_used);
      $display("checked %0d run words, saturated counters and a full result queue included.",
               words_checked);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/core/acec_pkg.sv
rtl/core/acec_if.sv
rtl/core/acec_column_stage.sv
rtl/core/acec_result_queue.sv
rtl/core/alignment_cigar_edit_classifier_top.sv
sim/alignment_cigar_edit_classifier_top_tb.sv
